>>> rtl/core/wbl_pkg.sv
// shared constants for the bilinear wavetable lookup unit
`timescale 1ns / 1ps

package wbl_pkg;

   // item codes carried in req_type
   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // table sample and fraction widths
   localparam int DATA_W = 16;
   localparam int FRAC_W = 16;

   // one half in Q0.16, moves the signed Q1.15 shape to unsigned
   localparam logic [FRAC_W-1:0] SHAPE_OFFSET = 16'h8000;

   // output saturation range
   localparam int SAMPLE_BITS = 16;
   localparam int SAT_HI = (1 << (SAMPLE_BITS - 1)) - 1;
   localparam int SAT_LO = -SAT_HI - 1;

   // entries in the queue between front and back
   localparam int QUEUE_DEPTH = 4;

endpackage

>>> rtl/core/wbl_if.sv
// valid/ready channel interfaces for lookup requests and results
`timescale 1ns / 1ps

interface wbl_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [3:0]         slice_sel;
   logic [7:0]         sample_sel;
   logic signed [15:0] write_sample;
   logic [15:0]        phase;
   logic signed [15:0] shape;

   modport source (
      output valid, req_type, slice_sel, sample_sel, write_sample, phase, shape,
      input  ready
   );
   modport sink (
      input  valid, req_type, slice_sel, sample_sel, write_sample, phase, shape,
      output ready
   );
endinterface

interface wbl_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;

   modport source (output valid, sample_out, input ready);
   modport sink (input valid, sample_out, output ready);
endinterface

>>> rtl/core/wbl_front.sv
// front end: classifies items and turns phase and shape into indices and fractions
`timescale 1ns / 1ps

module wbl_front import wbl_pkg::*; #(
   parameter int SAMPLES = 256,
   parameter int SLICES  = 16
) (
   wbl_req_if.sink                                               req_ch,
   output logic                                                  push_valid,
   input  logic                                                  push_ready,
   output logic [50+2*$clog2(SLICES)+2*$clog2(SAMPLES)-1:0]      push_data
);

   localparam int SA_W = $clog2(SAMPLES);
   localparam int SL_W = $clog2(SLICES);
   localparam int PW   = FRAC_W + SA_W;
   localparam int SW   = FRAC_W + SL_W;

   typedef struct packed {
      logic                      is_write;
      logic                      wr_ok;
      logic signed [DATA_W-1:0]  wdata;
      logic [SL_W-1:0]           k0;
      logic [SL_W-1:0]           k1;
      logic [SA_W-1:0]           i0;
      logic [SA_W-1:0]           i1;
      logic [FRAC_W-1:0]         t;
      logic [FRAC_W-1:0]         u;
   } item_type;

   logic [PW-1:0]     pidx;
   logic [SW-1:0]     sidx;
   logic [FRAC_W-1:0] shape_u;
   logic [SA_W-1:0]   li0;
   logic [SA_W-1:0]   li1;
   logic [SL_W-1:0]   lk0;
   logic [SL_W-1:0]   lk1;
   logic              is_write;
   item_type          item;

   // phase scaled by the sample count: index in the top bits, fraction below
   assign pidx = PW'(req_ch.phase) * PW'(SAMPLES);
   assign li0  = pidx[PW-1 -: SA_W];
   assign li1  = (li0 == SA_W'(SAMPLES - 1)) ? '0 : li0 + 1'b1;

   // shape offset to unsigned and scaled by the slice count
   assign shape_u = req_ch.shape + SHAPE_OFFSET;
   assign sidx    = SW'(shape_u) * SW'(SLICES);
   assign lk0     = sidx[SW-1 -: SL_W];
   assign lk1     = (lk0 == SL_W'(SLICES - 1)) ? '0 : lk0 + 1'b1;

   assign is_write = (req_ch.req_type == REQ_WRITE);

   // pack the item; a write carries its entry position in k0 and i0
   always_comb begin
      item.is_write = is_write;
      item.wr_ok    = (32'(req_ch.slice_sel) < 32'(SLICES))
                   && (32'(req_ch.sample_sel) < 32'(SAMPLES));
      item.wdata    = req_ch.write_sample;
      item.k0       = is_write ? SL_W'(req_ch.slice_sel) : lk0;
      item.k1       = lk1;
      item.i0       = is_write ? SA_W'(req_ch.sample_sel) : li0;
      item.i1       = li1;
      item.t        = pidx[FRAC_W-1:0];
      item.u        = sidx[FRAC_W-1:0];
   end

   assign push_valid   = req_ch.valid;
   assign push_data    = item;
   assign req_ch.ready = push_ready;

endmodule

>>> rtl/core/wbl_queue.sv
// small fifo that decouples the front end from the back end
`timescale 1ns / 1ps

module wbl_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = store_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // item storage
   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

>>> rtl/core/wbl_back.sv
// back end: table memory and the three interpolation steps
`timescale 1ns / 1ps

module wbl_back import wbl_pkg::*; #(
   parameter int SAMPLES = 256,
   parameter int SLICES  = 16
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              pop_valid,
   output logic                                              pop_ready,
   input  logic [50+2*$clog2(SLICES)+2*$clog2(SAMPLES)-1:0]  pop_data,
   wbl_rsp_if.source                                         rsp_ch
);

   localparam int SA_W = $clog2(SAMPLES);
   localparam int SL_W = $clog2(SLICES);
   localparam int DW_W = DATA_W + 1;
   localparam int PR_W = 2 * DW_W;

   typedef struct packed {
      logic                      is_write;
      logic                      wr_ok;
      logic signed [DATA_W-1:0]  wdata;
      logic [SL_W-1:0]           k0;
      logic [SL_W-1:0]           k1;
      logic [SA_W-1:0]           i0;
      logic [SA_W-1:0]           i1;
      logic [FRAC_W-1:0]         t;
      logic [FRAC_W-1:0]         u;
   } item_type;

   item_type item;
   logic     en;
   logic     pop;

   // two copies of the table, each with one write and two read ports
   logic signed [DATA_W-1:0] mem_a [SLICES][SAMPLES];
   logic signed [DATA_W-1:0] mem_b [SLICES][SAMPLES];

   // stage 1: table entries
   logic                     s1_valid_ff;
   logic signed [DATA_W-1:0] rd00_ff, rd01_ff, rd10_ff, rd11_ff;
   logic [FRAC_W-1:0]        t1_ff, u1_ff;

   // stage 2: phase products
   logic                     s2_valid_ff;
   logic signed [DW_W-1:0]   diff_a, diff_b;
   logic signed [PR_W-1:0]   prod_a, prod_b;
   logic signed [DW_W-1:0]   pa_ff, pa_in, pb_ff, pb_in;
   logic signed [DATA_W-1:0] a2_ff, b2_ff;
   logic [FRAC_W-1:0]        u2_ff;

   // stage 3: phase results
   logic                     s3_valid_ff;
   logic signed [DW_W:0]     sum_a, sum_b;
   logic signed [DATA_W-1:0] ya_ff, ya_in, yb_ff, yb_in;
   logic [FRAC_W-1:0]        u3_ff;

   // stage 4: shape product
   logic                     s4_valid_ff;
   logic signed [DW_W-1:0]   diff_y;
   logic signed [PR_W-1:0]   prod_y;
   logic signed [DW_W-1:0]   py_ff, py_in;
   logic signed [DATA_W-1:0] y4_ff;

   // output register
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_ff, out_in;
   logic signed [DW_W:0]     sum_y;
   logic signed [DATA_W-1:0] y_raw;
   logic signed [31:0]       y_wide;

   assign item      = pop_data;
   assign en        = !out_valid_ff || rsp_ch.ready;
   assign pop_ready = en;
   assign pop       = pop_valid && en;

   // table writes and reads, in item order
   always_ff @(posedge clock) begin
      if (pop && item.is_write && item.wr_ok) begin
         mem_a[item.k0][item.i0] <= item.wdata;
         mem_b[item.k0][item.i0] <= item.wdata;
      end
      if (pop && !item.is_write) begin
         rd00_ff <= mem_a[item.k0][item.i0];
         rd01_ff <= mem_a[item.k0][item.i1];
         rd10_ff <= mem_b[item.k1][item.i0];
         rd11_ff <= mem_b[item.k1][item.i1];
      end
   end

   // phase interpolation products, floor shift by the fraction width
   assign diff_a = DW_W'(rd01_ff) - DW_W'(rd00_ff);
   assign diff_b = DW_W'(rd11_ff) - DW_W'(rd10_ff);
   assign prod_a = $signed({1'b0, t1_ff}) * diff_a;
   assign prod_b = $signed({1'b0, t1_ff}) * diff_b;
   assign pa_in  = prod_a[FRAC_W +: DW_W];
   assign pb_in  = prod_b[FRAC_W +: DW_W];

   // phase results stay between their two entries
   assign sum_a = (DW_W + 1)'(a2_ff) + (DW_W + 1)'(pa_ff);
   assign sum_b = (DW_W + 1)'(b2_ff) + (DW_W + 1)'(pb_ff);
   assign ya_in = sum_a[DATA_W-1:0];
   assign yb_in = sum_b[DATA_W-1:0];

   // shape interpolation product
   assign diff_y = DW_W'(yb_ff) - DW_W'(ya_ff);
   assign prod_y = $signed({1'b0, u3_ff}) * diff_y;
   assign py_in  = prod_y[FRAC_W +: DW_W];

   // final sum and saturation
   assign sum_y  = (DW_W + 1)'(y4_ff) + (DW_W + 1)'(py_ff);
   assign y_raw  = sum_y[DATA_W-1:0];
   assign y_wide = 32'(y_raw);

   always_comb begin
      out_in = y_raw;
      if (y_wide > SAT_HI) begin
         out_in = DATA_W'(SAT_HI);
      end else if (y_wide < SAT_LO) begin
         out_in = DATA_W'(SAT_LO);
      end
   end

   // stage valids, all advancing together when the output can move
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= pop && !item.is_write;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         t1_ff  <= item.t;
         u1_ff  <= item.u;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         a2_ff  <= rd00_ff;
         b2_ff  <= rd10_ff;
         u2_ff  <= u1_ff;
         ya_ff  <= ya_in;
         yb_ff  <= yb_in;
         u3_ff  <= u2_ff;
         py_ff  <= py_in;
         y4_ff  <= ya_ff;
         out_ff <= out_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sample_out = out_ff;

endmodule

>>> rtl/core/wavetable_bilinear_lookup_unit.sv
// Bilinear wavetable lookup: SLICES x SAMPLES table of signed 16-bit entries. A write item
// stores one entry (positions outside the table are dropped, no result); a lookup item
// interpolates four entries in phase and then in shape and returns one result. One item is
// taken every clock cycle while the result side is not stalled; a lookup result passes the
// queue, the back-end stages and the output register. The rate is set by the table memory,
// kept as two copies with one write and two read ports each, so all four entries are read
// together. A four-item queue sits between the front end and the back end. An entry must be
// written before a lookup reads it; there is no clearing pass after reset.
`timescale 1ns / 1ps

module wavetable_bilinear_lookup_unit import wbl_pkg::*; #(
   parameter int SAMPLES = 256,
   parameter int SLICES  = 16
) (
   input  logic      clock,
   input  logic      reset,
   wbl_req_if.sink   req_ch,
   wbl_rsp_if.source rsp_ch
);

   localparam int ITEM_W = 50 + 2 * $clog2(SLICES) + 2 * $clog2(SAMPLES);

   logic              push_valid;
   logic              push_ready;
   logic [ITEM_W-1:0] push_data;
   logic              pop_valid;
   logic              pop_ready;
   logic [ITEM_W-1:0] pop_data;

   // classify items and compute indices
   wbl_front #(
      .SAMPLES (SAMPLES),
      .SLICES  (SLICES)
   ) u_front (
      .req_ch     (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // item queue
   wbl_queue #(
      .WIDTH (ITEM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_data   (push_data),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_data  (pop_data)
   );

   // table and interpolation
   wbl_back #(
      .SAMPLES (SAMPLES),
      .SLICES  (SLICES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .rsp_ch    (rsp_ch)
   );

   // no result is presented right after reset
   assert property (@(posedge clock) reset |=> !rsp_ch.valid)
      else $error("result valid after reset");

   // a stalled result freezes the back end, so nothing leaves the queue
   assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |-> !(pop_valid && pop_ready))
      else $error("queue popped while result stalled");

   // a full queue holds off new items
   assert property (@(posedge clock) disable iff (reset)
      !push_ready |-> !req_ch.ready)
      else $error("item accepted into full queue");

endmodule

>>> test/tb.sv
// self-checking testbench for the bilinear wavetable lookup unit
`timescale 1ns / 1ps

module tb;
   import wbl_pkg::*;

   localparam int N_SAMPLES    = 256;
   localparam int N_SLICES     = 16;
   localparam int ITEM_TARGET  = 1850;
   localparam int MAX_WAIT     = 12;
   localparam int DRAIN_CYCLES = 32;

   // one row of the directed stimulus table
   typedef struct {
      logic               kind;
      logic [3:0]         slice;
      logic [7:0]         sample;
      logic signed [15:0] value;
      logic [15:0]        phase;
      logic signed [15:0] shape;
      bit                 typed;
      logic signed [15:0] typed_out;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   wbl_req_if req_bus ();
   wbl_rsp_if rsp_bus ();

   // shadow copy of the wavetable and which entries hold a value
   logic signed [15:0] wave_mem     [N_SLICES][N_SAMPLES];
   bit                 wave_written [N_SLICES][N_SAMPLES];

   // interpolated samples still owed by the block, oldest first
   logic signed [15:0] pending_out [$];

   int mismatch_count = 0;
   int item_count     = 0;
   bit tx_steady      = 1'b0;
   bit rx_steady      = 1'b0;

   // directed items: extremes, both wraps, overwrite, mid-table slices
   stim_row_type directed_rows [20] = '{
      '{REQ_WRITE,  4'd0,  8'd0,   16'sh7fff, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd0,  8'd1,   16'sh8000, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd1,  8'd0,   16'sh0000, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd1,  8'd1,   16'sh1234, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      // lowest phase and lowest shape land exactly on entry (0,0)
      '{REQ_LOOKUP, 4'd0,  8'd0,   16'sh0000, 16'h0000, 16'sh8000, 1'b1, 16'sh7fff},
      // half-way between the two extreme entries
      '{REQ_LOOKUP, 4'd0,  8'd0,   16'sh0000, 16'h0080, 16'sh8000, 1'b0, 16'sh0000},
      // largest fractions inside slice 0 and sample 0
      '{REQ_LOOKUP, 4'd0,  8'd0,   16'sh0000, 16'h00ff, 16'sh8fff, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd15, 8'd255, 16'sh8000, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd15, 8'd0,   16'sh7fff, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd0,  8'd255, 16'shffff, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      // top phase and top shape wrap to sample 0 and slice 0
      '{REQ_LOOKUP, 4'd0,  8'd0,   16'sh0000, 16'hffff, 16'sh7fff, 1'b0, 16'sh0000},
      // last sample of last slice with zero fractions
      '{REQ_LOOKUP, 4'd0,  8'd0,   16'sh0000, 16'hff00, 16'sh7000, 1'b1, 16'sh8000},
      // overwrite of an entry already read
      '{REQ_WRITE,  4'd0,  8'd0,   16'sh8000, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_LOOKUP, 4'd0,  8'd0,   16'sh0000, 16'h0000, 16'sh8000, 1'b1, 16'sh8000},
      '{REQ_WRITE,  4'd8,  8'd0,   16'sh5555, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd8,  8'd1,   16'shaaaa, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd9,  8'd0,   16'sh0001, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      '{REQ_WRITE,  4'd9,  8'd1,   16'shfffe, 16'h0000, 16'sh0000, 1'b0, 16'sh0000},
      // zero shape picks the middle slice
      '{REQ_LOOKUP, 4'd0,  8'd0,   16'sh0000, 16'h0000, 16'sh0000, 1'b1, 16'sh5555},
      '{REQ_LOOKUP, 4'd0,  8'd0,   16'sh0000, 16'h0040, 16'sh0800, 1'b0, 16'sh0000}
   };

   wavetable_bilinear_lookup_unit #(
      .SAMPLES (N_SAMPLES),
      .SLICES  (N_SLICES)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample and slice neighbors plus their fractions for one lookup
   function automatic void find_taps(input logic [15:0] ph, input logic [15:0] sh,
                                     output int s0, output int s1,
                                     output int c0, output int c1,
                                     output longint t, output longint u);
      longint      pidx;
      longint      sidx;
      logic [15:0] sh_u;
      sh_u = sh + SHAPE_OFFSET;
      pidx = longint'(ph) * N_SAMPLES;
      s0   = int'((pidx >> 16) % N_SAMPLES);
      s1   = (s0 + 1) % N_SAMPLES;
      t    = pidx & 64'hffff;
      sidx = longint'(sh_u) * N_SLICES;
      c0   = int'((sidx >> 16) % N_SLICES);
      c1   = (c0 + 1) % N_SLICES;
      u    = sidx & 64'hffff;
   endfunction

   // linear step with floor shift of the product
   function automatic longint blend(longint a, longint b, longint frac);
      return a + ((frac * (b - a)) >>> 16);
   endfunction

   function automatic logic signed [15:0] interp_sample(logic [15:0] ph, logic [15:0] sh);
      int     s0, s1, c0, c1;
      longint t, u, ya, yb, y;
      find_taps(ph, sh, s0, s1, c0, c1, t, u);
      ya = blend(wave_mem[c0][s0], wave_mem[c0][s1], t);
      yb = blend(wave_mem[c1][s0], wave_mem[c1][s1], t);
      y  = blend(ya, yb, u);
      if (y > SAT_HI) y = SAT_HI;
      if (y < SAT_LO) y = SAT_LO;
      return y[15:0];
   endfunction

   task automatic report_mismatch(string what, logic signed [15:0] want,
                                  logic signed [15:0] got);
      $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, what, want, got);
      mismatch_count++;
   endtask

   // drive one item after a random gap and wait until it is taken
   task automatic send_item(input logic kind, input logic [3:0] slice,
                            input logic [7:0] sample, input logic signed [15:0] value,
                            input logic [15:0] phase, input logic signed [15:0] shape,
                            input logic signed [15:0] want_out);
      int gap;
      gap = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= kind;
      req_bus.slice_sel    <= slice;
      req_bus.sample_sel   <= sample;
      req_bus.write_sample <= value;
      req_bus.phase        <= phase;
      req_bus.shape        <= shape;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      item_count++;
      if (kind == REQ_WRITE) begin
         wave_mem[slice][sample]     = value;
         wave_written[slice][sample] = 1'b1;
      end else begin
         pending_out.push_back(want_out);
      end
      if ($urandom_range(0, 39) == 0) tx_steady = !tx_steady;
   endtask

   // write any of the four neighbors not yet holding a value, then look up
   task automatic run_lookup(input logic [15:0] ph, input logic signed [15:0] sh,
                             input bit typed, input logic signed [15:0] typed_out);
      int     s0, s1, c0, c1;
      longint t, u;
      int     tap_slice  [4];
      int     tap_sample [4];
      find_taps(ph, sh, s0, s1, c0, c1, t, u);
      tap_slice  = '{c0, c0, c1, c1};
      tap_sample = '{s0, s1, s0, s1};
      for (int k = 0; k < 4; k++) begin
         if (!wave_written[tap_slice[k]][tap_sample[k]])
            send_item(REQ_WRITE, 4'(tap_slice[k]), 8'(tap_sample[k]), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'sh0000);
      end
      send_item(REQ_LOOKUP, 4'($urandom), 8'($urandom), 16'($urandom), ph, sh,
                typed ? typed_out : interp_sample(ph, sh));
   endtask

   // result side: random stalls, check each item against the oldest expectation
   initial begin
      int                 stall;
      logic signed [15:0] want;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (pending_out.size() == 0) begin
            report_mismatch("unexpected sample_out", 'x, rsp_bus.sample_out);
         end else begin
            want = pending_out.pop_front();
            if (rsp_bus.sample_out !== want)
               report_mismatch("sample_out", want, rsp_bus.sample_out);
         end
         if ($urandom_range(0, 39) == 0) rx_steady = !rx_steady;
      end
   end

   // stimulus: reset, directed table, random items, drain
   initial begin
      bit                 paused;
      logic [15:0]        ph;
      logic signed [15:0] sh;
      logic signed [15:0] value;
      paused = 1'b0;
      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.req_type     <= REQ_WRITE;
      req_bus.slice_sel    <= '0;
      req_bus.sample_sel   <= '0;
      req_bus.write_sample <= '0;
      req_bus.phase        <= '0;
      req_bus.shape        <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].kind == REQ_WRITE)
            send_item(REQ_WRITE, directed_rows[r].slice, directed_rows[r].sample,
                      directed_rows[r].value, directed_rows[r].phase,
                      directed_rows[r].shape, 16'sh0000);
         else
            run_lookup(directed_rows[r].phase, directed_rows[r].shape,
                       directed_rows[r].typed, directed_rows[r].typed_out);
      end

      while (item_count < ITEM_TARGET) begin
         // hold off once until every owed result has come back
         if (!paused && item_count >= ITEM_TARGET / 2) begin
            req_bus.valid <= 1'b0;
            while (pending_out.size() != 0) @(posedge clock);
            paused = 1'b1;
         end
         if ($urandom_range(0, 9) < 6) begin
            case ($urandom_range(0, 7))
               0:       ph = 16'h0000;
               1:       ph = 16'hffff;
               default: ph = 16'($urandom);
            endcase
            case ($urandom_range(0, 9))
               0:       sh = 16'sh8000;
               1:       sh = 16'sh7fff;
               2:       sh = 16'sh0000;
               default: sh = 16'($urandom);
            endcase
            run_lookup(ph, sh, 1'b0, 16'sh0000);
         end else begin
            case ($urandom_range(0, 7))
               0:       value = 16'sh8000;
               1:       value = 16'sh7fff;
               default: value = 16'($urandom);
            endcase
            send_item(REQ_WRITE, 4'($urandom), 8'($urandom), value,
                      16'($urandom), 16'($urandom), 16'sh0000);
         end
      end

      req_bus.valid <= 1'b0;
      while (pending_out.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

   // overall time limit
   initial begin
      #5_000_000;
      $display("tb NOT OK");
      $finish;
   end

endmodule
